// ----- design/sgb_pkg.sv -----
`timescale 1ns / 1ps
package sgb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_RADIUS = 3;
	localparam int LINES      = 2 * MAX_RADIUS;
	localparam int TAPS       = 2 * MAX_RADIUS + 1;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 11;
	localparam int WID_W  = 12;
	localparam int HGT_W  = 13;
	localparam int RAD_W  = 2;
	localparam int COEF_W = 16;
	localparam int VERT_W = 16;
	localparam int CFG_AW = 3;

	// register indexes of the configuration port
	localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_RADIUS = 3'd2;
	localparam logic [CFG_AW-1:0] REG_COEF0  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_COEF1  = 3'd4;
	localparam logic [CFG_AW-1:0] REG_COEF2  = 3'd5;
	localparam logic [CFG_AW-1:0] REG_COEF3  = 3'd6;

	// reset values
	localparam logic [WID_W-1:0]  RST_WIDTH  = 12'd640;
	localparam logic [HGT_W-1:0]  RST_HEIGHT = 13'd480;
	localparam logic [RAD_W-1:0]  RST_RADIUS = 2'd2;
	localparam logic [COEF_W-1:0] RST_COEF0  = 16'd13193;
	localparam logic [COEF_W-1:0] RST_COEF1  = 16'd8002;
	localparam logic [COEF_W-1:0] RST_COEF2  = 16'd1785;
	localparam logic [COEF_W-1:0] RST_COEF3  = 16'd0;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

// ----- design/sgb_if.sv -----
`timescale 1ns / 1ps
interface sgb_pix_if import sgb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface sgb_res_if import sgb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic [PIX_W-1:0] value;
	logic             last;

	modport source (output valid, output out_row, output out_col, output value,
		output last, input ready);
	modport sink (input valid, input out_row, input out_col, input value,
		input last, output ready);
endinterface

// ----- design/separable_gaussian_blur_top.sv -----
`timescale 1ns / 1ps
// one pixel word at a time: accept, column read, 2R+1 vertical taps, finish,
// 2R+1 horizontal taps, finish, then up to two result words (R = radius);
// border columns skip the vertical taps, the horizontal taps run only where a
// filtered word is due, and result stalls hold the block before the next pixel
// reset: configuration registers take their reset values, counters and column window clear;
// the line store is not cleared and holds garbage until rows are written
module separable_gaussian_blur_top import sgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sgb_pix_if.sink           pixels,
	sgb_res_if.source         results,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [COEF_W-1:0] cfg_data
);

	localparam int MEM_AW = $clog2(MAX_WIDTH);
	localparam int MEM_DW = LINES * PIX_W;
	localparam int SLOT_W = $clog2(LINES);
	localparam int K_W    = $clog2(TAPS);
	localparam int ACC_W  = 2 * COEF_W + K_W + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_VMAC, S_VFIN, S_HMAC, S_HFIN, S_EMIT
	} state_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] value;
		logic             last;
	} res_t;

	state_t            state_q;
	logic [WID_W-1:0]  wid_q;
	logic [HGT_W-1:0]  hgt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [COEF_W-1:0] coef_q [4];

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;
	logic [VERT_W-1:0] cw_q [TAPS];
	logic [PIX_W-1:0]  pix_q;
	logic [MEM_DW-1:0] word_q;
	logic [ACC_W-1:0]  acc_q;
	logic [K_W-1:0]    k_q;
	logic              vborder_q, filt_q, pass_q;
	res_t              out_q, sec_q;
	logic              sec_pend_q;

	logic [MEM_DW-1:0] mem [MAX_WIDTH];
	logic [MEM_DW-1:0] rd_q;

	// effective geometry
	logic [WID_W-1:0] w_eff;
	logic [HGT_W-1:0] h_eff;
	always_comb begin
		w_eff = wid_q;
		if (wid_q == '0) w_eff = WID_W'(1);
		else if (wid_q > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
		h_eff = hgt_q;
		if (hgt_q == '0) h_eff = HGT_W'(1);
		else if (hgt_q > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
	end

	logic accept;
	assign pixels.ready = (state_q == S_IDLE);
	assign accept       = pixels.valid && (state_q == S_IDLE);

	// column word with the arriving pixel placed in its row slot
	logic [MEM_DW-1:0] wr_word;
	always_comb begin
		wr_word = rd_q;
		wr_word[slot_q*PIX_W +: PIX_W] = pix_q;
	end

	// line store: one word per column, all slots side by side
	always_ff @(posedge clk) begin
		if (accept) rd_q <= mem[col_q[MEM_AW-1:0]];
		if (state_q == S_READ) mem[col_q[MEM_AW-1:0]] <= wr_word;
	end

	// tap distance and source pixel of tap k (k rows back)
	logic [RAD_W-1:0]  tap_dist;
	logic [PIX_W-1:0]  tap_pix;
	logic [PIX_W-1:0]  rad_pix;
	logic [SLOT_W:0]   sidx, ridx;
	always_comb begin
		if (k_q > K_W'(rad_q)) tap_dist = RAD_W'(k_q - K_W'(rad_q));
		else tap_dist = RAD_W'(K_W'(rad_q) - k_q);
		sidx = (SLOT_W+1)'(slot_q) + (SLOT_W+1)'(LINES) - (SLOT_W+1)'(k_q);
		if (sidx >= (SLOT_W+1)'(LINES)) sidx = sidx - (SLOT_W+1)'(LINES);
		if (k_q == '0) tap_pix = pix_q;
		else tap_pix = word_q[sidx[SLOT_W-1:0]*PIX_W +: PIX_W];
		ridx = (SLOT_W+1)'(slot_q) + (SLOT_W+1)'(LINES) - (SLOT_W+1)'(rad_q);
		if (ridx >= (SLOT_W+1)'(LINES)) ridx = ridx - (SLOT_W+1)'(LINES);
		if (rad_q == '0) rad_pix = pix_q;
		else rad_pix = word_q[ridx[SLOT_W-1:0]*PIX_W +: PIX_W];
	end

	// shared multiplier
	logic [COEF_W-1:0]   mul_b;
	logic [2*COEF_W-1:0] prod;
	always_comb begin
		if (state_q == S_VMAC) mul_b = {{(COEF_W-PIX_W){1'b0}}, tap_pix};
		else mul_b = cw_q[k_q];
		prod = coef_q[tap_dist] * mul_b;
	end

	// vertical clamp and reduction to 8 fraction bits
	localparam logic [ACC_W-1:0] VCLAMP = ACC_W'(255) << 15;
	logic [ACC_W-1:0]  vsat;
	logic [ACC_W-1:0]  vrnd;
	logic [VERT_W-1:0] vert;
	always_comb begin
		vsat = (acc_q > VCLAMP) ? VCLAMP : acc_q;
		vrnd = (vsat + ACC_W'(64)) >> 7;
		if (vborder_q) vert = {rad_pix, 8'd0};
		else vert = vrnd[VERT_W-1:0];
	end

	// horizontal rounding and saturation
	logic [ACC_W-1:0] hrnd;
	logic [PIX_W-1:0] hval;
	always_comb begin
		hrnd = (acc_q + (ACC_W'(1) << 22)) >> 23;
		hval = (hrnd > ACC_W'(PIX_MAX)) ? PIX_MAX : hrnd[PIX_W-1:0];
	end

	// geometry tests on the arriving position
	logic [K_W-1:0]   two_rad;
	logic [WID_W:0]   c_plus;
	logic [HGT_W:0]   r_plus;
	logic             col_edge, row_edge, filt_now;
	logic             col_end, row_end;
	always_comb begin
		two_rad  = K_W'(rad_q) << 1;
		c_plus   = (WID_W+1)'(col_q) + (WID_W+1)'(rad_q);
		r_plus   = (HGT_W+1)'(row_q) + (HGT_W+1)'(rad_q);
		col_edge = (col_q < COL_W'(rad_q)) || (c_plus >= (WID_W+1)'(w_eff));
		row_edge = (row_q < ROW_W'(rad_q)) || (r_plus >= (HGT_W+1)'(h_eff));
		filt_now = (row_q >= ROW_W'(two_rad)) && (col_q >= COL_W'(two_rad))
			&& (HGT_W'(row_q) < h_eff) && (WID_W'(col_q) < w_eff);
		col_end  = (WID_W'(col_q) + WID_W'(1)) >= w_eff;
		row_end  = (HGT_W'(row_q) + HGT_W'(1)) >= h_eff;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q     <= RST_WIDTH;
			hgt_q     <= RST_HEIGHT;
			rad_q     <= RST_RADIUS;
			coef_q[0] <= RST_COEF0;
			coef_q[1] <= RST_COEF1;
			coef_q[2] <= RST_COEF2;
			coef_q[3] <= RST_COEF3;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WIDTH:  wid_q     <= cfg_data[WID_W-1:0];
				REG_HEIGHT: hgt_q     <= cfg_data[HGT_W-1:0];
				REG_RADIUS: rad_q     <= cfg_data[RAD_W-1:0];
				REG_COEF0:  coef_q[0] <= cfg_data;
				REG_COEF1:  coef_q[1] <= cfg_data;
				REG_COEF2:  coef_q[2] <= cfg_data;
				REG_COEF3:  coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_q      <= '0;
			col_q      <= '0;
			slot_q     <= '0;
			for (int i = 0; i < TAPS; i++) cw_q[i] <= '0;
			sec_pend_q <= 1'b0;
			k_q        <= '0;
			acc_q      <= '0;
			vborder_q  <= 1'b0;
			filt_q     <= 1'b0;
			pass_q     <= 1'b0;
			pix_q      <= '0;
			word_q     <= '0;
			out_q      <= '0;
			sec_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pix_q   <= pixels.pixel;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					word_q    <= rd_q;
					vborder_q <= col_edge;
					filt_q    <= filt_now;
					pass_q    <= col_edge || row_edge;
					k_q       <= '0;
					acc_q     <= '0;
					state_q   <= col_edge ? S_VFIN : S_VMAC;
				end
				S_VMAC: begin
					acc_q <= acc_q + ACC_W'(prod);
					if (k_q == two_rad) state_q <= S_VFIN;
					else k_q <= k_q + K_W'(1);
				end
				S_VFIN: begin
					for (int i = 1; i < TAPS; i++) cw_q[i] <= cw_q[i-1];
					cw_q[0] <= vert;
					k_q     <= '0;
					acc_q   <= '0;
					state_q <= filt_q ? S_HMAC : S_HFIN;
				end
				S_HMAC: begin
					acc_q <= acc_q + ACC_W'(prod);
					if (k_q == two_rad) state_q <= S_HFIN;
					else k_q <= k_q + K_W'(1);
				end
				S_HFIN: begin
					// filtered word goes first, passed-through word second
					if (filt_q) begin
						out_q.row   <= row_q - ROW_W'(rad_q);
						out_q.col   <= col_q - COL_W'(rad_q);
						out_q.value <= hval;
						out_q.last  <= col_end && row_end && !pass_q;
						sec_q.row   <= row_q;
						sec_q.col   <= col_q;
						sec_q.value <= pix_q;
						sec_q.last  <= col_end && row_end;
						sec_pend_q  <= pass_q;
					end else begin
						out_q.row   <= row_q;
						out_q.col   <= col_q;
						out_q.value <= pix_q;
						out_q.last  <= col_end && row_end;
						sec_pend_q  <= 1'b0;
					end
					state_q <= (filt_q || pass_q) ? S_EMIT : S_IDLE;
					// advance position
					if (col_end) begin
						col_q <= '0;
						if (row_end) begin
							row_q  <= '0;
							slot_q <= '0;
						end else begin
							row_q  <= row_q + ROW_W'(1);
							slot_q <= (slot_q == SLOT_W'(LINES - 1)) ? '0
								: slot_q + SLOT_W'(1);
						end
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				S_EMIT: begin
					if (results.ready) begin
						if (sec_pend_q) begin
							out_q      <= sec_q;
							sec_pend_q <= 1'b0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word
	assign results.valid   = (state_q == S_EMIT);
	assign results.out_row = out_q.row;
	assign results.out_col = out_q.col;
	assign results.value   = out_q.value;
	assign results.last    = out_q.last;

endmodule

// ----- tb/sv/sgb_blur_checker.sv -----
`timescale 1ns / 1ps
module sgb_blur_checker import sgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sgb_pix_if                pixels,
	sgb_res_if                results,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [COEF_W-1:0] cfg_data,
	output int                pending,
	output int                errors
);

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] value;
		logic             last;
	} blur_word_t;

	// shadow of the block's registers and state
	logic [WID_W-1:0]  img_w;
	logic [HGT_W-1:0]  img_h;
	logic [RAD_W-1:0]  radius;
	logic [COEF_W-1:0] taps_w [0:MAX_RADIUS];
	logic [PIX_W-1:0]  rows_mem [0:LINES*MAX_WIDTH-1];
	logic [VERT_W-1:0] col_win [0:TAPS-1];
	int                cur_row;
	int                cur_col;
	blur_word_t        expected_words[$];

	assign pending = expected_words.size();

	function automatic longint unsigned tap_weight(int tap_dist);
		if (tap_dist <= MAX_RADIUS)
			return longint'(taps_w[tap_dist]);
		return 0;
	endfunction

	// source pixel 'back' rows above the arriving one, same column
	function automatic int unsigned src_pixel(int back, int slot, int col, int pix);
		int s;
		if (back == 0)
			return pix;
		s = (slot + LINES - (back % LINES)) % LINES;
		return rows_mem[s * MAX_WIDTH + col];
	endfunction

	// advance the blur by one source pixel and queue what it produces
	task automatic blur_step(input logic [PIX_W-1:0] pix);
		int w, h, rd, r, c, slot, d, n;
		longint unsigned acc, val;
		int unsigned vert;
		blur_word_t wd;
		blur_word_t made[2];
		w = img_w;
		h = img_h;
		rd = radius;
		r = cur_row;
		c = cur_col;
		n = 0;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		if (rd > MAX_RADIUS) rd = MAX_RADIUS;
		slot = r % LINES;

		// vertical pass for row r-rd at this column
		if (c < rd || c + rd >= w) begin
			vert = src_pixel(rd, slot, c, pix) << 8;
		end else begin
			acc = 0;
			for (d = -rd; d <= rd; d++)
				acc += tap_weight(d < 0 ? -d : d) * src_pixel(rd - d, slot, c, pix);
			if (acc > (longint'(255) << 15)) acc = longint'(255) << 15;
			vert = int'((acc + 64) >> 7);
		end
		for (int k = TAPS - 1; k > 0; k--)
			col_win[k] = col_win[k-1];
		col_win[0] = vert[VERT_W-1:0];
		rows_mem[slot * MAX_WIDTH + c] = pix;

		// horizontal pass completes the pixel at (r-rd, c-rd)
		if (r >= 2 * rd && c >= 2 * rd && r < h && c < w) begin
			acc = 0;
			for (d = -rd; d <= rd; d++)
				acc += tap_weight(d < 0 ? -d : d) * longint'(col_win[rd - d]);
			val = (acc + (longint'(1) << 22)) >> 23;
			if (val > 255) val = 255;
			made[n] = '{row: ROW_W'(r - rd), col: COL_W'(c - rd), value: PIX_W'(val), last: 1'b0};
			n++;
		end
		// border pixel passes through
		if (r < rd || r + rd >= h || c < rd || c + rd >= w) begin
			made[n] = '{row: ROW_W'(r), col: COL_W'(c), value: pix, last: 1'b0};
			n++;
		end

		if (c + 1 >= w) begin
			cur_col = 0;
			if (r + 1 >= h) begin
				cur_row = 0;
				if (n > 0) made[n-1].last = 1'b1;
			end else begin
				cur_row = (r + 1) & 12'hFFF;
			end
		end else begin
			cur_col = (c + 1) & 11'h7FF;
		end
		for (int i = 0; i < n; i++) begin
			wd = made[i];
			expected_words = {expected_words, wd};
		end
	endtask

	// watch config writes, pixel words and result words
	always @(posedge clk or negedge arst_n) begin
		blur_word_t exp_w;
		if (!arst_n) begin
			img_w = RST_WIDTH;
			img_h = RST_HEIGHT;
			radius = RST_RADIUS;
			taps_w[0] = RST_COEF0;
			taps_w[1] = RST_COEF1;
			taps_w[2] = RST_COEF2;
			taps_w[3] = RST_COEF3;
			for (int k = 0; k < TAPS; k++) col_win[k] = '0;
			cur_row = 0;
			cur_col = 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_WIDTH: img_w = cfg_data[WID_W-1:0];
					REG_HEIGHT: img_h = cfg_data[HGT_W-1:0];
					REG_RADIUS: radius = cfg_data[RAD_W-1:0];
					REG_COEF0: taps_w[0] = cfg_data;
					REG_COEF1: taps_w[1] = cfg_data;
					REG_COEF2: taps_w[2] = cfg_data;
					REG_COEF3: taps_w[3] = cfg_data;
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word row %0d col %0d value %0d",
						results.out_row, results.out_col, results.value);
					errors++;
				end else begin
					exp_w = expected_words.pop_front();
					if (results.out_row !== exp_w.row) begin
						$error("out_row: expected %0d, got %0d", exp_w.row, results.out_row);
						errors++;
					end
					if (results.out_col !== exp_w.col) begin
						$error("out_col: expected %0d, got %0d", exp_w.col, results.out_col);
						errors++;
					end
					if (results.value !== exp_w.value) begin
						$error("value: expected %0d, got %0d", exp_w.value, results.value);
						errors++;
					end
					if (results.last !== exp_w.last) begin
						$error("last: expected %0d, got %0d", exp_w.last, results.last);
						errors++;
					end
				end
			end
			if (pixels.valid && pixels.ready)
				blur_step(pixels.pixel);
		end
	end

	initial errors = 0;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import sgb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [COEF_W-1:0] cfg_data;
	int                pending;
	int                errors;
	int                cycles;
	int                sent;
	bit                calm;
	bit                hold_req;

	sgb_pix_if pix_ch ();
	sgb_res_if res_ch ();

	separable_gaussian_blur_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix_ch),
		.results  (res_ch),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	sgb_blur_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix_ch),
		.results  (res_ch),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.pending  (pending),
		.errors   (errors)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// cycle limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// wait until every expected word is out and the block has drained
	task automatic drain();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_regs(input logic [COEF_W-1:0] w, input logic [COEF_W-1:0] h,
			input logic [COEF_W-1:0] rd, input logic [COEF_W-1:0] c0,
			input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
			input logic [COEF_W-1:0] c3);
		logic [COEF_W-1:0] vals [7];
		logic [CFG_AW-1:0] idx [7];
		vals = '{w, h, rd, c0, c1, c2, c3};
		idx = '{REG_WIDTH, REG_HEIGHT, REG_RADIUS, REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3};
		drain();
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// offer one pixel word and wait for it to be taken
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= p;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return PIX_MAX;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'hFFFF;
			3: return COEF_W'($urandom_range(0, 65535));
			default: return COEF_W'($urandom_range(0, 16384));
		endcase
	endfunction

	// one whole frame of the given effective size
	task automatic send_frame(input int w, input int h);
		for (int i = 0; i < w * h; i++)
			send_pixel(rand_pixel());
	endtask

	initial begin
		int w, h;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_WIDTH;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		sent = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: 5x5 frame, radius 2, alternating extremes
		write_regs(16'd5, 16'd5, 16'd2, RST_COEF0, RST_COEF1, RST_COEF2, RST_COEF3);
		for (int i = 0; i < 25; i++)
			send_pixel((i % 2) ? PIX_MAX : 8'd0);

		// random frames over random geometry and weights
		while (sent < 500) begin
			w = $urandom_range(1, 16);
			h = $urandom_range(1, 12);
			write_regs(COEF_W'(w), COEF_W'(h), COEF_W'($urandom_range(0, 3)),
				rand_coef(), rand_coef(), rand_coef(), rand_coef());
			if (sent > 200)
				hold_req = 1'b1;
			send_frame(w, h);
			if ($urandom_range(0, 2) == 0)
				send_frame(w, h);
		end

		// size extremes, no idling
		calm = 1'b1;
		write_regs(16'd9, 16'd7, 16'd3, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
		send_frame(9, 7);
		write_regs(16'd0, 16'd0, 16'd3, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_frame(1, 1);

		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
design/sgb_pkg.sv
design/sgb_if.sv
design/separable_gaussian_blur_top.sv
tb/sv/sgb_blur_checker.sv
tb/sv/tb.sv
